/* sv/aes_pkg.sv */
// Package with AES types, tables and round functions.
`default_nettype none
package aes_pkg;
  localparam int MaxRoundsDefault = 14;
  localparam logic [2:0] RegMode = 3'd0;
  localparam logic [2:0] RegKey0 = 3'd1;
  localparam logic [2:0] RegKey1 = 3'd2;
  localparam logic [2:0] RegKey2 = 3'd3;
  localparam logic [2:0] RegKey3 = 3'd4;

  typedef struct packed {
    logic        req_type;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } req_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } resp_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[x];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd1: r = 8'h01;
      4'd2: r = 8'h02;
      4'd3: r = 8'h04;
      4'd4: r = 8'h08;
      4'd5: r = 8'h10;
      4'd6: r = 8'h20;
      4'd7: r = 8'h40;
      4'd8: r = 8'h80;
      4'd9: r = 8'h1b;
      4'd10: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] word_sbox(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the state sits at bits [127-8i -: 8].
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = sbox(s[127-8*i -: 8]);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) t[4*c+r] = b[4*((c+r)&3)+r];
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      if (!last) begin
        t[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        t[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
        t[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
        t[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
    return o;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r] = s[127-8*(4*c+r) -: 8];
        x2[r] = xt(a[r]);
        x4[r] = xt(x2[r]);
        x8[r] = xt(x4[r]);
        m9[r] = x8[r] ^ a[r];
      end
      for (int r = 0; r < 4; r++)
        o[127-8*(4*c+r) -: 8] = (x8[r] ^ x4[r] ^ x2[r]) ^
          (m9[(r+1)&3] ^ x2[(r+1)&3]) ^ (m9[(r+2)&3] ^ x4[(r+2)&3]) ^ m9[(r+3)&3];
    end
    return o;
  endfunction

  // Inverse shift rows and inverse substitution.
  function automatic logic [127:0] dec_sub(input logic [127:0] s);
    logic [7:0] b [16];
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[127-8*(4*c+r) -: 8] = inv_sbox(b[4*((c+3*r)&3)+r]);
    return o;
  endfunction
endpackage
`default_nettype wire

/* sv/aes_ram.sv */
// Generic single-port-write RAM with a registered read.
`default_nettype none
module aes_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* sv/aes_block_cipher.sv */
// Top level of the AES-128/AES-256 block cipher.
// Usage: write key_size_mode (index 0) and key words (indexes 1 to 4) through
// cfg_we/cfg_index/cfg_data while idle. Pulse start with req while busy is low;
// a transaction is accepted when start is high and busy is low. The result
// appears on resp with done high for exactly one cycle and cannot be stalled.
// The round keys live in a memory of MAX_ROUNDS+1 rows of 128 bits, one row per
// round key, with a registered read. After any register write the first
// transaction first expands the schedule one 32-bit word at a time, loading
// the key words and generating the rest, writing each completed row.
// Processing then reads one row per round, with the memory read per round
// setting the pace, through S_RD, S_RUN, S_LAST and S_DONE until done rises.
// busy stays high from acceptance until done; a new transaction can be
// accepted while done is high, though not while busy is high, once the
// schedule is valid.
// Reset clears the mode, the keys and the schedule-valid flag; the memory needs
// no clearing since it is always expanded before use.
`default_nettype none
module aes_block_cipher #(
  parameter int MAX_ROUNDS = aes_pkg::MaxRoundsDefault
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire aes_pkg::req_t  req,
  output logic                busy,
  output logic                done,
  output aes_pkg::resp_t      resp,
  input  wire logic           cfg_we,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [63:0]    cfg_data
);
  localparam int Rows = MAX_ROUNDS + 1;
  localparam int RowBits = $clog2(Rows + 1);
  localparam int AddrBits = $clog2(Rows);
  localparam logic [3:0] MaxR = 4'(MAX_ROUNDS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_KEXP = 6'b000010, S_RD = 6'b000100,
    S_RUN = 6'b001000, S_LAST = 6'b010000, S_DONE = 6'b100000
  } state_t;

  state_t state;
  logic mode;
  logic [63:0] key [4];
  logic ready;
  logic dir;
  logic [127:0] st;
  logic [3:0] nr;
  logic [3:0] rnd;
  logic [5:0] widx;
  logic [255:0] win;       // last eight schedule words, newest in [31:0]
  logic [127:0] row;       // row being assembled
  logic we;
  logic [AddrBits-1:0] waddr, raddr;
  logic [127:0] rk;
  logic [31:0] tw, nw;
  logic [3:0] nkw;
  logic [RowBits-1:0] total_rows;

  aes_ram #(.Width(128), .Depth(Rows)) u_rk (
    .clk(clk), .we(we), .waddr(waddr), .wdata({row[95:0], nw}),
    .raddr(raddr), .rdata(rk)
  );

  always_comb begin
    nr = mode ? ((MaxR < 4'd14) ? MaxR : 4'd14) : ((MaxR < 4'd10) ? MaxR : 4'd10);
    nkw = mode ? 4'd8 : 4'd4;
    total_rows = RowBits'(nr) + RowBits'(1);
    tw = win[31:0];
    if (widx < 6'(nkw)) begin
      nw = (widx[2:1] == 2'd0) ? (widx[0] ? key[0][31:0] : key[0][63:32]) :
           (widx[2:1] == 2'd1) ? (widx[0] ? key[1][31:0] : key[1][63:32]) :
           (widx[2:1] == 2'd2) ? (widx[0] ? key[2][31:0] : key[2][63:32]) :
                                 (widx[0] ? key[3][31:0] : key[3][63:32]);
    end else begin
      if (mode ? (widx[2:0] == 3'd0) : (widx[1:0] == 2'd0))
        tw = aes_pkg::word_sbox({win[23:0], win[31:24]}) ^
             {aes_pkg::rcon(mode ? 4'(widx[5:3]) : widx[5:2]), 24'd0};
      else if (mode && widx[2:0] == 3'd4)
        tw = aes_pkg::word_sbox(win[31:0]);
      nw = (mode ? win[255:224] : win[127:96]) ^ tw;
    end
    we = (state == S_KEXP) && (widx[1:0] == 2'd3);
    waddr = AddrBits'(widx[5:2]);
    raddr = AddrBits'(rnd);
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= 1'b0;
      for (int i = 0; i < 4; i++) key[i] <= '0;
      ready <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          aes_pkg::RegMode: begin mode <= cfg_data[0]; ready <= 1'b0; end
          aes_pkg::RegKey0: begin key[0] <= cfg_data; ready <= 1'b0; end
          aes_pkg::RegKey1: begin key[1] <= cfg_data; ready <= 1'b0; end
          aes_pkg::RegKey2: begin key[2] <= cfg_data; ready <= 1'b0; end
          aes_pkg::RegKey3: begin key[3] <= cfg_data; ready <= 1'b0; end
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            dir <= req.req_type;
            st <= {req.block_high, req.block_low};
            widx <= '0;
            rnd <= req.req_type ? nr : 4'd0;
            state <= ready ? S_RD : S_KEXP;
          end
        end
        S_KEXP: begin
          win <= {win[223:0], nw};
          row <= {row[95:0], nw};
          widx <= widx + 6'd1;
          if (we && (widx[5:2] == 4'(total_rows - RowBits'(1)))) begin
            ready <= 1'b1;
            state <= S_RD;
          end
        end
        S_RD: begin
          // Initial key addition row is being read.
          rnd <= dir ? rnd - 4'd1 : rnd + 4'd1;
          state <= S_RUN;
        end
        S_RUN: begin
          if (rnd == (dir ? nr - 4'd1 : 4'd1)) begin
            st <= st ^ rk;       // initial AddRoundKey
          end else if (!dir) begin
            st <= aes_pkg::enc_round(st, 1'b0) ^ rk;
          end else begin
            st <= aes_pkg::inv_mix(aes_pkg::dec_sub(st) ^ rk);
          end
          if (rnd == (dir ? 4'd0 : nr)) state <= S_LAST;
          else rnd <= dir ? rnd - 4'd1 : rnd + 4'd1;
        end
        S_LAST: begin
          if (!dir) st <= aes_pkg::enc_round(st, 1'b1) ^ rk;
          else st <= aes_pkg::dec_sub(st) ^ rk;
          state <= S_DONE;
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign resp.result_high = st[127:64];
  assign resp.result_low = st[63:0];
endmodule
`default_nettype wire
